/* rtl/elevation_profile_record_parser_defines.svh */
// ----------------------------------------------------------------------------
// Elevation profile record parser: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ELEVATION_PROFILE_RECORD_PARSER_DEFINES_SVH
`define ELEVATION_PROFILE_RECORD_PARSER_DEFINES_SVH

// Check a property outside reset
`define EPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included
`define EPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/epr_pkg.sv */
// ----------------------------------------------------------------------------
// Elevation profile record parser package
// Shared constants, result codes and the sample decode function.
// ----------------------------------------------------------------------------
package epr_pkg;

    localparam int ADDR_W     = 4;
    localparam int HEAD_BYTES = 8;
    localparam int SUM_BYTES  = 4;

    localparam logic [7:0]  SENTINEL  = 8'hAA;
    localparam logic [15:0] VOID_CODE = 16'hFFFF;
    localparam logic [14:0] MAG_LIMIT = 15'd12000;

    typedef enum logic [1:0] {
        REG_SAMPLES_PER_PROFILE = 2'd0,
        REG_PROFILES_PER_CELL   = 2'd1,
        REG_NO_DATA_VALUE       = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_NO_SENTINEL = 2'd1,
        STATUS_BAD_SUM     = 2'd2
    } record_status_t;

    function automatic logic [15:0] decode_sample(input logic [15:0] code,
                                                  input logic [15:0] no_data);
        logic [14:0] mag;
        mag = code[14:0];
        if (code == VOID_CODE) begin
            return no_data;
        end else if (!code[15]) begin
            return code;
        end else if (mag > MAG_LIMIT) begin
            return code;
        end else begin
            return 16'(-{1'b0, mag});
        end
    endfunction

endpackage

/* rtl/elevation_profile_record_parser.sv */
// ----------------------------------------------------------------------------
// Elevation profile record parser
// Parses byte-serial elevation profile records, decodes samples and reports
// per-record status with checksum and sentinel checks.
// ----------------------------------------------------------------------------
// Path: a byte request reaches the result through the input register and the result register.
// Throughput: one byte per cycle while the result output is not stalled; the byte path is a single add and compare.
// Reset: synchronous, active low; clears record state, profile count and
// handshake valids, and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module elevation_profile_record_parser #(
    parameter int MAX_SAMPLES = 121
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [epr_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_result_kind,
    output logic signed [15:0]         m_elevation,
    output logic [1:0]                 m_record_status,
    output logic [6:0]                 m_profile_number,
    output logic [6:0]                 m_sample_number,
    output logic                       m_cell_done
);

    localparam int POS_W = $clog2(2 * MAX_SAMPLES + epr_pkg::HEAD_BYTES
                                  + epr_pkg::SUM_BYTES + 1);
    localparam int EXT_W = (POS_W > 8) ? POS_W : 8;

    logic [6:0]  spp_reg;
    logic [6:0]  ppc_reg;
    logic [15:0] no_data_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0] sum_reg, sum_next;
    logic [23:0] stored_reg, stored_next;
    logic [7:0]  high_reg, high_next;
    logic        sent_bad_reg, sent_bad_next;
    logic [6:0]  sample_cnt_reg, sample_cnt_next;
    logic [6:0]  profile_cnt_reg, profile_cnt_next;

    logic        m_valid_reg;
    logic        kind_reg, kind_next;
    logic [15:0] elev_reg, elev_next;
    logic [1:0]  status_reg, status_next;
    logic [6:0]  prof_num_reg, prof_num_next;
    logic [6:0]  samp_num_reg, samp_num_next;
    logic        cell_done_reg, cell_done_next;
    logic        emit;

    logic             advance;
    logic             cfg_write;
    logic [EXT_W-1:0] s_eff, data_end, rec_end, pos_ext;
    logic [7:0]       p_eff;
    logic [31:0]      stored_full;
    logic             close_rec, in_sum, in_head, prof_done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spp_reg     <= 7'd121;
            ppc_reg     <= 7'd121;
            no_data_reg <= 16'h8001;
        end else if (cfg_write) begin
            case (epr_pkg::reg_index_t'(paddr[3:2]))
                epr_pkg::REG_SAMPLES_PER_PROFILE: spp_reg     <= pwdata[6:0];
                epr_pkg::REG_PROFILES_PER_CELL:   ppc_reg     <= pwdata[6:0];
                epr_pkg::REG_NO_DATA_VALUE:       no_data_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (epr_pkg::reg_index_t'(paddr[3:2]))
            epr_pkg::REG_SAMPLES_PER_PROFILE: prdata = {25'd0, spp_reg};
            epr_pkg::REG_PROFILES_PER_CELL:   prdata = {25'd0, ppc_reg};
            epr_pkg::REG_NO_DATA_VALUE:       prdata = {16'd0, no_data_reg};
            default:                          prdata = 32'd0;
        endcase
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Record decode
    always_comb begin
        s_eff = EXT_W'(spp_reg);
        if (s_eff < EXT_W'(2)) begin
            s_eff = EXT_W'(2);
        end else if (s_eff > EXT_W'(MAX_SAMPLES)) begin
            s_eff = EXT_W'(MAX_SAMPLES);
        end
        p_eff       = (ppc_reg < 7'd2) ? 8'd2 : {1'b0, ppc_reg};
        data_end    = EXT_W'(epr_pkg::HEAD_BYTES) + {s_eff[EXT_W-2:0], 1'b0};
        rec_end     = data_end + EXT_W'(epr_pkg::SUM_BYTES);
        pos_ext     = EXT_W'(pos_reg);
        close_rec   = (pos_ext + EXT_W'(1)) >= rec_end;
        in_sum      = pos_ext >= data_end;
        in_head     = pos_ext < EXT_W'(epr_pkg::HEAD_BYTES);
        stored_full = {stored_reg, in_byte_reg};
        prof_done   = ({1'b0, profile_cnt_reg} + 8'd1) >= p_eff;

        pos_next         = pos_reg;
        sum_next         = sum_reg;
        stored_next      = stored_reg;
        high_next        = high_reg;
        sent_bad_next    = sent_bad_reg;
        sample_cnt_next  = sample_cnt_reg;
        profile_cnt_next = profile_cnt_reg;

        emit           = 1'b0;
        kind_next      = epr_pkg::KIND_SAMPLE;
        elev_next      = 16'd0;
        status_next    = epr_pkg::STATUS_OK;
        prof_num_next  = profile_cnt_reg;
        samp_num_next  = 7'd0;
        cell_done_next = 1'b0;

        if (close_rec) begin
            emit      = 1'b1;
            kind_next = epr_pkg::KIND_STATUS;
            if (sent_bad_reg) begin
                status_next = epr_pkg::STATUS_NO_SENTINEL;
            end else if (stored_full != sum_reg) begin
                status_next = epr_pkg::STATUS_BAD_SUM;
            end
            cell_done_next   = prof_done;
            profile_cnt_next = prof_done ? 7'd0 : profile_cnt_reg + 7'd1;
            pos_next         = '0;
            sum_next         = 32'd0;
            stored_next      = 24'd0;
            high_next        = 8'd0;
            sent_bad_next    = 1'b0;
            sample_cnt_next  = 7'd0;
        end else begin
            pos_next = pos_reg + POS_W'(1);
            if (in_sum) begin
                stored_next = {stored_reg[15:0], in_byte_reg};
            end else begin
                sum_next = sum_reg + {24'd0, in_byte_reg};
                if (pos_reg == '0 && in_byte_reg != epr_pkg::SENTINEL) begin
                    sent_bad_next = 1'b1;
                end
                if (!in_head) begin
                    if (!pos_reg[0]) begin
                        high_next = in_byte_reg;
                    end else begin
                        emit            = 1'b1;
                        elev_next       = epr_pkg::decode_sample({high_reg, in_byte_reg},
                                                                 no_data_reg);
                        samp_num_next   = sample_cnt_reg;
                        sample_cnt_next = sample_cnt_reg + 7'd1;
                    end
                end
            end
        end
    end

    // Record state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            sum_reg         <= 32'd0;
            stored_reg      <= 24'd0;
            high_reg        <= 8'd0;
            sent_bad_reg    <= 1'b0;
            sample_cnt_reg  <= 7'd0;
            profile_cnt_reg <= 7'd0;
        end else if (advance) begin
            pos_reg         <= pos_next;
            sum_reg         <= sum_next;
            stored_reg      <= stored_next;
            high_reg        <= high_next;
            sent_bad_reg    <= sent_bad_next;
            sample_cnt_reg  <= sample_cnt_next;
            profile_cnt_reg <= profile_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= emit;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            kind_reg      <= kind_next;
            elev_reg      <= elev_next;
            status_reg    <= status_next;
            prof_num_reg  <= prof_num_next;
            samp_num_reg  <= samp_num_next;
            cell_done_reg <= cell_done_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_elevation      = elev_reg;
    assign m_record_status  = status_reg;
    assign m_profile_number = prof_num_reg;
    assign m_sample_number  = samp_num_reg;
    assign m_cell_done      = cell_done_reg;

endmodule

/* rtl/epr_checker.sv */
// ----------------------------------------------------------------------------
// Elevation profile record parser checker
// Port-level assertions on result ordering, stalls and reset.
// ----------------------------------------------------------------------------
`include "elevation_profile_record_parser_defines.svh"

module epr_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_result_kind,
    input logic signed [15:0]         m_elevation,
    input logic [1:0]                 m_record_status,
    input logic [6:0]                 m_profile_number,
    input logic [6:0]                 m_sample_number,
    input logic                       m_cell_done
);

    logic        new_cell_reg;
    logic [33:0] result_bus;

    assign result_bus = {m_result_kind, m_elevation, m_record_status, m_profile_number,
                         m_sample_number, m_cell_done};

    // Track that the last delivered result was a status that closed a cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            new_cell_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            new_cell_reg <= (m_result_kind == epr_pkg::KIND_STATUS) && m_cell_done;
        end
    end

    `EPR_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(result_bus), "result changed while stalled")
    `EPR_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_valid, "result valid after reset")
    `EPR_ASSERT(a_stall_cause, !s_ready |-> m_valid && !m_ready, "request stalled without a waiting result")
    `EPR_ASSERT(a_cell_restart, m_valid && new_cell_reg |-> m_profile_number == 7'd0, "profile count did not restart")

endmodule

bind elevation_profile_record_parser epr_checker u_epr_checker (.*);

/* sim/elevation_profile_record_parser_tb.sv */
// ----------------------------------------------------------------------------
// Elevation profile record parser testbench
// Streams profile records built from random samples and faults into the
// parser, with random idling on both sides and length, count and no-data
// changes between phases. Every byte request is run through a cycle-free
// model of the parser, and each result is compared with the oldest one due.
// ----------------------------------------------------------------------------
module elevation_profile_record_parser_tb;

    localparam int MAX_SAMPLES     = 121;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 8;
    localparam int QUIET_LIMIT     = 3000;
    localparam int REPORT_LIMIT    = 10;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef enum int {
        FAULT_NONE,
        FAULT_SENTINEL,
        FAULT_SUM,
        FAULT_BOTH,
        FAULT_NOISE
    } record_fault_t;

    typedef struct packed {
        epr_pkg::result_kind_t   kind;
        logic [15:0]             elevation;
        epr_pkg::record_status_t status;
        logic [6:0]              profile;
        logic [6:0]              sample;
        logic                    cell_done;
    } parser_result_t;

    class profile_result_scoreboard;
        logic [6:0]     samples_reg;
        logic [6:0]     profiles_reg;
        logic [15:0]    no_data_reg;
        int unsigned    byte_pos;
        logic [31:0]    byte_sum;
        logic [23:0]    sum_shift;
        logic [7:0]     high_byte;
        bit             no_sentinel;
        logic [6:0]     sample_cnt;
        logic [6:0]     profile_cnt;
        parser_result_t elevation_results_due[$];
        int unsigned    results_seen;
        int unsigned    mismatches;

        function new();
            samples_reg  = 7'd121;
            profiles_reg = 7'd121;
            no_data_reg  = 16'h8001;
            profile_cnt  = '0;
            results_seen = 0;
            mismatches   = 0;
            clear_record();
        endfunction

        function void clear_record();
            byte_pos    = 0;
            byte_sum    = '0;
            sum_shift   = '0;
            high_byte   = '0;
            no_sentinel = 1'b0;
            sample_cnt  = '0;
        endfunction

        function void set_register(epr_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                epr_pkg::REG_SAMPLES_PER_PROFILE: samples_reg  = value[6:0];
                epr_pkg::REG_PROFILES_PER_CELL:   profiles_reg = value[6:0];
                epr_pkg::REG_NO_DATA_VALUE:       no_data_reg  = value[15:0];
                default: ;
            endcase
        endfunction

        function int samples_in_record();
            if (samples_reg < 7'd2) return 2;
            if (int'(samples_reg) > MAX_SAMPLES) return MAX_SAMPLES;
            return int'(samples_reg);
        endfunction

        function logic [15:0] elevation_of(logic [15:0] code);
            if (code == epr_pkg::VOID_CODE) return no_data_reg;
            if (!code[15]) return code;
            if (code[14:0] > epr_pkg::MAG_LIMIT) return code;
            return 16'h0000 - {1'b0, code[14:0]};
        endfunction

        function int pending();
            return elevation_results_due.size();
        endfunction

        function void note_byte(logic [7:0] value);
            int unsigned    data_end;
            int unsigned    pos_now;
            int unsigned    cell_len;
            parser_result_t r;
            data_end = epr_pkg::HEAD_BYTES + 2 * samples_in_record();
            cell_len = (profiles_reg < 7'd2) ? 2 : int'(profiles_reg);
            r = '0;
            if (byte_pos + 1 >= data_end + epr_pkg::SUM_BYTES) begin
                r.kind = epr_pkg::KIND_STATUS;
                if (no_sentinel) begin
                    r.status = epr_pkg::STATUS_NO_SENTINEL;
                end else if ({sum_shift, value} != byte_sum) begin
                    r.status = epr_pkg::STATUS_BAD_SUM;
                end else begin
                    r.status = epr_pkg::STATUS_OK;
                end
                r.profile   = profile_cnt;
                r.cell_done = (int'(profile_cnt) + 1 >= cell_len);
                profile_cnt = r.cell_done ? 7'd0 : 7'(profile_cnt + 7'd1);
                clear_record();
                elevation_results_due = {elevation_results_due, r};
                return;
            end
            pos_now  = byte_pos;
            byte_pos = byte_pos + 1;
            if (pos_now >= data_end) begin
                sum_shift = {sum_shift[15:0], value};
                return;
            end
            byte_sum = byte_sum + 32'(value);
            if (pos_now == 0 && value != epr_pkg::SENTINEL) no_sentinel = 1'b1;
            if (pos_now < epr_pkg::HEAD_BYTES) return;
            if (((pos_now - epr_pkg::HEAD_BYTES) % 2) == 0) begin
                high_byte = value;
                return;
            end
            r.kind      = epr_pkg::KIND_SAMPLE;
            r.elevation = elevation_of({high_byte, value});
            r.status    = epr_pkg::STATUS_OK;
            r.profile   = profile_cnt;
            r.sample    = sample_cnt;
            sample_cnt  = 7'(sample_cnt + 7'd1);
            elevation_results_due = {elevation_results_due, r};
        endfunction

        function void check_result(parser_result_t got);
            parser_result_t want;
            results_seen++;
            if (elevation_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d unexpected: kind %0d elev %0d status %0d prof %0d",
                             results_seen, got.kind, $signed(got.elevation), got.status,
                             got.profile);
                return;
            end
            want = elevation_results_due.pop_front();
            if (got.kind !== want.kind || got.elevation !== want.elevation ||
                got.status !== want.status || got.profile !== want.profile ||
                got.sample !== want.sample || got.cell_done !== want.cell_done) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display(
                        "result %0d exp: kind %0d elev %0d stat %0d prof %0d samp %0d done %0d",
                        results_seen, want.kind, $signed(want.elevation), want.status,
                        want.profile, want.sample, want.cell_done);
                    $display(
                        "result %0d act: kind %0d elev %0d stat %0d prof %0d samp %0d done %0d",
                        results_seen, got.kind, $signed(got.elevation), got.status,
                        got.profile, got.sample, got.cell_done);
                end
            end
        endfunction
    endclass

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [epr_pkg::ADDR_W-1:0] paddr       = '0;
    logic [31:0]                pwdata      = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic [7:0]                 s_data_byte = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic                       m_result_kind;
    logic signed [15:0]         m_elevation;
    logic [1:0]                 m_record_status;
    logic [6:0]                 m_profile_number;
    logic [6:0]                 m_sample_number;
    logic                       m_cell_done;

    profile_result_scoreboard board = new();
    parser_result_t           observed;
    logic [7:0]               record_bytes[$];
    int                       tx_idle_pct    = 17;
    int                       rx_idle_pct    = 17;
    int                       rx_hold_cycles = 0;
    int                       quiet_cycles   = 0;

    elevation_profile_record_parser #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_elevation      (m_elevation),
        .m_record_status  (m_record_status),
        .m_profile_number (m_profile_number),
        .m_sample_number  (m_sample_number),
        .m_cell_done      (m_cell_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed.kind      = epr_pkg::result_kind_t'(m_result_kind);
            observed.elevation = m_elevation;
            observed.status    = epr_pkg::record_status_t'(m_record_status);
            observed.profile   = m_profile_number;
            observed.sample    = m_sample_number;
            observed.cell_done = m_cell_done;
            board.check_result(observed);
        end
        if (rx_hold_cycles > 0) begin
            m_ready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("elevation_profile_record_parser_tb failed");
        $finish;
    end

    function automatic logic [15:0] random_code();
        case ($urandom_range(9))
            0:       return epr_pkg::VOID_CODE;
            1, 2:    return {1'b0, 15'($urandom)};
            3, 4:    return {1'b1, 15'($urandom_range(12000))};
            5:       return {1'b1, 15'($urandom_range(12001, 32767))};
            6: begin
                case ($urandom_range(5))
                    0:       return 16'h0000;
                    1:       return 16'h7FFF;
                    2:       return 16'h8000;
                    3:       return {1'b1, epr_pkg::MAG_LIMIT};
                    4:       return {1'b1, epr_pkg::MAG_LIMIT + 15'd1};
                    default: return 16'hFFFE;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void build_record(input logic [15:0] codes[$],
                                         input record_fault_t fault);
        logic [31:0] sum;
        logic [7:0]  lead;
        sum  = '0;
        lead = epr_pkg::SENTINEL;
        record_bytes.delete();
        if (fault == FAULT_SENTINEL || fault == FAULT_BOTH) begin
            lead = 8'($urandom);
            if (lead == epr_pkg::SENTINEL) lead = ~epr_pkg::SENTINEL;
        end
        record_bytes = {record_bytes, lead};
        repeat (epr_pkg::HEAD_BYTES - 1) record_bytes = {record_bytes, 8'($urandom)};
        foreach (codes[i]) begin
            record_bytes = {record_bytes, codes[i][15:8]};
            record_bytes = {record_bytes, codes[i][7:0]};
        end
        foreach (record_bytes[i]) sum += 32'(record_bytes[i]);
        if (fault == FAULT_SUM || fault == FAULT_BOTH) sum ^= 32'h1 << $urandom_range(31);
        record_bytes = {record_bytes, sum[31:24]};
        record_bytes = {record_bytes, sum[23:16]};
        record_bytes = {record_bytes, sum[15:8]};
        record_bytes = {record_bytes, sum[7:0]};
        if (fault == FAULT_NOISE)
            foreach (record_bytes[i]) record_bytes[i] = 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] value);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_byte(value);
    endtask

    task automatic send_record(input int limit);
        for (int i = 0; i < limit; i++) send_byte(record_bytes[i]);
    endtask

    task automatic wait_until_drained();
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input epr_pkg::reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
        @(posedge aclk);
    endtask

    task automatic configure(input logic [6:0] s_raw, input logic [6:0] p_raw,
                             input logic [15:0] no_data);
        s_valid <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(epr_pkg::REG_SAMPLES_PER_PROFILE, 32'(s_raw));
        write_reg(epr_pkg::REG_PROFILES_PER_CELL, 32'(p_raw));
        write_reg(epr_pkg::REG_NO_DATA_VALUE, 32'(no_data));
    endtask

    task automatic run_phase(input logic [6:0] s_raw, input logic [6:0] p_raw,
                             input logic [15:0] no_data, input int n_records,
                             input int tail_bytes, input int pause_at,
                             input int tx_pct, input int rx_pct, input int hold);
        logic [15:0]   codes[$];
        record_fault_t fault;
        int            r;
        configure(s_raw, p_raw, no_data);
        tx_idle_pct    = tx_pct;
        rx_idle_pct    = rx_pct;
        rx_hold_cycles = hold;
        for (int n = 0; n < n_records + (tail_bytes > 0 ? 1 : 0); n++) begin
            if (n == pause_at) begin
                s_valid <= 1'b0;
                @(posedge aclk);
                wait_until_drained();
            end
            codes.delete();
            repeat (board.samples_in_record()) codes = {codes, random_code()};
            r = $urandom_range(99);
            fault = r < 8  ? FAULT_SENTINEL :
                    r < 16 ? FAULT_SUM :
                    r < 20 ? FAULT_BOTH :
                    r < 25 ? FAULT_NOISE : FAULT_NONE;
            build_record(codes, fault);
            send_record(n < n_records ? record_bytes.size() : tail_bytes);
        end
    endtask

    initial begin
        logic [15:0] directed_codes[$];
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lengths below range clamp to two samples and two profiles
        configure(7'd0, 7'd0, 16'h8000);
        directed_codes = {epr_pkg::VOID_CODE, {1'b1, epr_pkg::MAG_LIMIT}};
        build_record(directed_codes, FAULT_NONE);
        send_record(record_bytes.size());
        directed_codes = {{1'b1, epr_pkg::MAG_LIMIT + 15'd1}, 16'h7FFF};
        build_record(directed_codes, FAULT_BOTH);
        send_record(record_bytes.size());

        run_phase(7'd3, 7'd3, 16'h7FFF, 12, 0, -1, 17, 17, 0);
        run_phase(7'd2, 7'd5, 16'($urandom), 10, 0, -1, 0, 0, 0);
        // stop deep inside a full-length record, then shrink it
        run_phase(7'd127, 7'd127, 16'hFFFF, 1, 100, -1, 17, 17, 0);
        run_phase(7'd2, 7'd2, 16'($urandom), 12, 0, -1, 17, 17, HOLD_OFF_CYCLES);
        run_phase(7'd6, 7'd4, 16'($urandom), 8, 0, 4, 17, 17, 0);

        s_valid <= 1'b0;
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("elevation_profile_record_parser_tb passed");
        else
            $display("elevation_profile_record_parser_tb failed");
        $finish;
    end

endmodule
